/* sv/task_priority_queue_macros.svh */
// Assertion macros for the task priority queue.
// Included by the top level; needs nothing else.
`ifndef TASK_PRIORITY_QUEUE_MACROS_SVH
`define TASK_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on clock, off while reset is high
`define TPQ_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("task_priority_queue: assertion failed");

// Next-cycle implication, clocked on clock, off while reset is high
`define TPQ_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("task_priority_queue: assertion failed");

`else

`define TPQ_ASSERT_IMPL(name, ante, cons)
`define TPQ_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* sv/tpq_pkg.sv */
// Shared types and codes for the task priority queue.
// No dependencies.
package tpq_pkg;

   // Operation codes
   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_EDIT   = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_EXEC   = 2'd3
   } mode_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   localparam int TASK_ID_BITS = 8;
   localparam int FIELD_BITS   = 16;

   // Request beat
   typedef struct packed {
      mode_type                mode;
      logic [TASK_ID_BITS-1:0] task_id;
      logic [FIELD_BITS-1:0]   user_id;
      logic [FIELD_BITS-1:0]   priority_req;
   } req_type;

   // Response beat
   typedef struct packed {
      status_type            status;
      logic [FIELD_BITS-1:0] top_user;
   } rsp_type;

endpackage

/* sv/task_priority_queue.sv */
// Task priority queue top level: sequencer, task table RAM and max tracker.
// Depends on tpq_pkg, tpq_ram, tpq_best and task_priority_queue_macros.svh.
//
//   channel   ports                          beat
//   request   req_valid req_ready req_data   req_type: mode, task_id, user_id, priority_req
//   response  rsp_valid rsp_ready rsp_data   rsp_type: status, top_user
//
// Add, edit and remove issue the table read at accept, check and write the slot in
// S_CHECK, then load the output register from S_POST once it is free.
// Execute top scans the table: the single table read port feeds one comparator a
// slot per cycle; on an empty table it answers without a scan.
// After reset a clearing pass writes every slot, with req_ready low.
// One request is in work at a time; a new one is taken while the last response waits.
module task_priority_queue
   import tpq_pkg::*;
#(
   parameter int TASK_SLOTS    = 256,
   parameter int USER_BITS     = 16,
   parameter int PRIORITY_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "task_priority_queue_macros.svh"

   localparam int SLOT_BITS = $clog2(TASK_SLOTS);
   localparam int WORD_BITS = 1 + USER_BITS + PRIORITY_BITS;
   localparam logic [SLOT_BITS:0] SLOT_COUNT = (SLOT_BITS+1)'(TASK_SLOTS);
   localparam logic [SLOT_BITS:0] SLOT_LAST  = (SLOT_BITS+1)'(TASK_SLOTS - 1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_CHECK = 6'b000100,
      S_SCAN  = 6'b001000,
      S_FINAL = 6'b010000,
      S_POST  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOT_BITS:0]   cnt_ff, cnt_in;
   logic [SLOT_BITS:0]   live_ff, live_in;
   logic                 pend_ff, pend_in;
   logic [SLOT_BITS-1:0] pend_slot_ff, pend_slot_in;
   req_type              req_ff, req_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Table RAM port signals
   logic                 wr_en, rd_en;
   logic [SLOT_BITS-1:0] wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data;

   // Fields of the word just read
   logic                     old_valid;
   logic [USER_BITS-1:0]     old_user;
   logic [PRIORITY_BITS-1:0] old_pri;

   logic                     best_start, best_found;
   logic [SLOT_BITS-1:0]     best_slot;
   logic [USER_BITS-1:0]     best_user;

   logic                     in_table;
   logic [SLOT_BITS-1:0]     req_slot, cur_slot;

   assign old_valid = rd_data[WORD_BITS-1];
   assign old_user  = rd_data[PRIORITY_BITS +: USER_BITS];
   assign old_pri   = rd_data[PRIORITY_BITS-1:0];

   assign in_table  = (32'(req_data.task_id) < TASK_SLOTS);
   assign req_slot  = SLOT_BITS'(req_data.task_id);
   assign cur_slot  = SLOT_BITS'(req_ff.task_id);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Task table: {valid, user, priority} per slot
   tpq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (TASK_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared comparator for the execute-top scan
   tpq_best #(
      .SLOT_BITS     (SLOT_BITS),
      .USER_BITS     (USER_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_best (
      .clock          (clock),
      .reset          (reset),
      .start          (best_start),
      .sample         (pend_ff),
      .entry_valid    (old_valid),
      .entry_slot     (pend_slot_ff),
      .entry_user     (old_user),
      .entry_priority (old_pri),
      .found          (best_found),
      .best_slot      (best_slot),
      .best_user      (best_user)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      live_in      = live_ff;
      pend_in      = 1'b0;
      pend_slot_in = pend_slot_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[SLOT_BITS-1:0];
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = req_slot;
      best_start   = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // Clearing pass over the table after reset
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[SLOT_BITS-1:0];
            if (cnt_ff == SLOT_LAST) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         // Accept a beat; start the table access or post an early result
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.mode == MODE_EXEC) begin
                  if (live_ff == '0) begin
                     res_in   = '{status: STATUS_EMPTY, top_user: '0};
                     state_in = S_POST;
                  end else begin
                     cnt_in     = '0;
                     best_start = 1'b1;
                     state_in   = S_SCAN;
                  end
               end else if (!in_table) begin
                  res_in   = '{status: STATUS_NOT_FOUND, top_user: '0};
                  state_in = S_POST;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = req_slot;
                  state_in = S_CHECK;
               end
            end
         end
         // Read-modify-write of one slot
         S_CHECK: begin
            wr_addr  = cur_slot;
            res_in   = '{status: STATUS_OK, top_user: '0};
            state_in = S_POST;
            case (req_ff.mode)
               MODE_ADD: begin
                  wr_en   = 1'b1;
                  wr_data = {1'b1, USER_BITS'(req_ff.user_id),
                             PRIORITY_BITS'(req_ff.priority_req)};
                  if (!old_valid) begin
                     live_in = live_ff + 1'b1;
                  end
               end
               MODE_EDIT: begin
                  if (old_valid) begin
                     wr_en   = 1'b1;
                     wr_data = {1'b1, old_user, PRIORITY_BITS'(req_ff.priority_req)};
                  end else begin
                     res_in.status = STATUS_NOT_FOUND;
                  end
               end
               MODE_REMOVE: begin
                  if (old_valid) begin
                     wr_en   = 1'b1;
                     wr_data = {1'b0, old_user, old_pri};
                     live_in = live_ff - 1'b1;
                  end else begin
                     res_in.status = STATUS_NOT_FOUND;
                  end
               end
               default: begin
                  res_in.status = STATUS_NOT_FOUND;
               end
            endcase
         end
         // One slot read per cycle; the comparator sees it in the next cycle
         S_SCAN: begin
            if (cnt_ff != SLOT_COUNT) begin
               rd_en        = 1'b1;
               rd_addr      = cnt_ff[SLOT_BITS-1:0];
               pend_in      = 1'b1;
               pend_slot_in = cnt_ff[SLOT_BITS-1:0];
               cnt_in       = cnt_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = S_FINAL;
            end
         end
         // Drop the winner and return its user, or report empty if none was found
         S_FINAL: begin
            state_in = S_POST;
            if (best_found) begin
               wr_en   = 1'b1;
               wr_addr = best_slot;
               wr_data = '0;
               live_in = live_ff - 1'b1;
               res_in  = '{status: STATUS_OK, top_user: FIELD_BITS'(best_user)};
            end else begin
               res_in  = '{status: STATUS_EMPTY, top_user: '0};
            end
         end
         // Hand the result to the output register once it is free
         S_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            cnt_in   = '0;
            state_in = S_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         live_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         live_ff      <= live_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      req_ff       <= req_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Checks
   `TPQ_ASSERT_IMPL(a_live_bound, 1'b1, live_ff <= SLOT_COUNT)
   `TPQ_ASSERT_IMPL(a_empty_means_none, (state_ff == S_POST) && (res_ff.status == STATUS_EMPTY), live_ff == '0)
   `TPQ_ASSERT_IMPL(a_final_has_live, (state_ff == S_FINAL) && best_found, live_ff != '0)
   `TPQ_ASSERT_IMPL(a_user_only_ok, rsp_valid_ff && (rsp_data_ff.status != STATUS_OK), rsp_data_ff.top_user == '0)
   `TPQ_ASSERT_NEXT(a_post_loads, (state_ff == S_POST) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (rsp_data_ff == $past(res_ff)))

endmodule

/* sv/tpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tpq_best.sv */
// Running-maximum tracker: one comparator shared over the whole table scan.
// No dependencies.
module tpq_best #(
   parameter int SLOT_BITS     = 8,
   parameter int USER_BITS     = 16,
   parameter int PRIORITY_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     sample,
   input  logic                     entry_valid,
   input  logic [SLOT_BITS-1:0]     entry_slot,
   input  logic [USER_BITS-1:0]     entry_user,
   input  logic [PRIORITY_BITS-1:0] entry_priority,
   output logic                     found,
   output logic [SLOT_BITS-1:0]     best_slot,
   output logic [USER_BITS-1:0]     best_user
);

   logic                     found_ff, found_in;
   logic [SLOT_BITS-1:0]     slot_ff;
   logic [USER_BITS-1:0]     user_ff;
   logic [PRIORITY_BITS-1:0] pri_ff;
   logic                     take;

   // Slots arrive in rising order, so >= hands ties to the larger task id
   assign take = sample && entry_valid && (!found_ff || (entry_priority >= pri_ff));

   always_comb begin
      found_in = found_ff;
      if (start) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // Best entry payload
   always_ff @(posedge clock) begin
      if (take && !start) begin
         slot_ff <= entry_slot;
         user_ff <= entry_user;
         pri_ff  <= entry_priority;
      end
   end

   assign found     = found_ff;
   assign best_slot = slot_ff;
   assign best_user = user_ff;

endmodule
